[hdl/smm_pkg.sv]
// Shared constants, types and a helper function for the square matrix multiplier.
`default_nettype none
package smm_pkg;
    localparam int MaxSide = 8;
    localparam int IdxW    = $clog2(MaxSide);
    localparam int AddrW   = 2 * IdxW;
    localparam int Depth   = MaxSide * MaxSide;
    localparam int DataW   = 64;
    localparam int MulW    = 32;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } state_t;

    // Control handed from the sequencer to the cell chain.
    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } cell_ctl_t;

    // Low 64 bits of a 64x64 product from 32-bit partial products.
    function automatic logic [DataW-1:0] wrap_mul(input logic [DataW-1:0] a,
                                                  input logic [DataW-1:0] b);
        logic [2*MulW-1:0] ll;
        logic [2*MulW-1:0] lh;
        logic [2*MulW-1:0] hl;
        ll = a[MulW-1:0] * b[MulW-1:0];
        lh = a[MulW-1:0] * b[DataW-1:MulW];
        hl = a[DataW-1:MulW] * b[MulW-1:0];
        return ll + {lh[MulW-1:0], {MulW{1'b0}}} + {hl[MulW-1:0], {MulW{1'b0}}};
    endfunction
endpackage
`default_nettype wire

[hdl/smm_cell.sv]
// One multiply-accumulate cell of the chain: multiplies, accumulates, shifts.
`default_nettype none
module smm_cell
    import smm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctl_t        ctl,
    input  wire logic             mul_en,
    input  wire logic [DataW-1:0] a_in,
    input  wire logic [DataW-1:0] b_in,
    input  wire logic [DataW-1:0] shift_in,
    output logic      [DataW-1:0] acc_out
);
    logic [2*MulW-1:0] ll_reg, lh_reg, hl_reg;
    logic [DataW-1:0]  acc_reg, acc_next;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            ll_reg <= a_in[MulW-1:0] * b_in[MulW-1:0];
            lh_reg <= a_in[MulW-1:0] * b_in[DataW-1:MulW];
            hl_reg <= a_in[DataW-1:MulW] * b_in[MulW-1:0];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
            acc_next = '0;
        else if (ctl.load)
            acc_next = acc_reg + ll_reg + {lh_reg[MulW-1:0], {MulW{1'b0}}}
                       + {hl_reg[MulW-1:0], {MulW{1'b0}}};
        else if (ctl.shift)
            acc_next = shift_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc_out = acc_reg;
endmodule
`default_nettype wire

[hdl/square_matrix_multiply.sv]
// Top level: operand memories, k-step sequencer and a chain of MAC cells.
// Loads are taken one per cycle, back to back, while the block is idle. A
// compute item holds the block for n rows of n read/multiply/accumulate k
// steps plus n emit beats at side n, plus any output stalls; the first result
// is presented once the last k step of row 0 is done.
// One row of n results is formed in parallel by the cells, then shifted out.
// Reset (rst_n, async low) clears control and sets size_log2 to 3; the
// operand memories hold no reset value and must be written before use.
`default_nettype none
module square_matrix_multiply
    import smm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_wdata,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       operation,
    input  wire logic [2:0]       row,
    input  wire logic [2:0]       col,
    input  wire logic [63:0]      value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [2:0]       out_row,
    output logic      [2:0]       out_col,
    output logic      [63:0]      out_value,
    output logic                  last
);
    logic [1:0] size_log2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_log2_reg <= 2'd3;
        else if (cfg_we)
            size_log2_reg <= cfg_wdata;
    end

    // side - 1, saturated to storage
    logic [IdxW-1:0] side_m1;
    always_comb
    begin
        if (({1'b0, size_log2_reg} + 3'd0) >= 3'($clog2(MaxSide)))
            side_m1 = IdxW'(MaxSide - 1);
        else
            side_m1 = IdxW'((4'd1 << size_log2_reg) - 4'd1);
    end

    // Operand memories: A read by (row,k), B read row-wide by k.
    logic [DataW-1:0] mem_a [Depth];
    logic [DataW-1:0] mem_b [MaxSide][MaxSide];
    logic [DataW-1:0] a_rd_reg;
    logic [DataW-1:0] b_rd_reg [MaxSide];

    state_t state_reg, state_next;
    logic [IdxW-1:0] i_reg, i_next, k_reg, k_next, j_reg, j_next;

    logic in_fire, out_fire;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (in_fire && operation == OP_LOAD_A)
            mem_a[{row, col}] <= value;
        if (in_fire && operation == OP_LOAD_B)
            mem_b[row][col] <= value;
        a_rd_reg <= mem_a[{i_reg, k_reg}];
        for (int c = 0; c < MaxSide; c++)
            b_rd_reg[c] <= mem_b[k_reg][c];
    end

    // Next state: read -> mul -> acc per k, then emit the row.
    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        k_next = k_reg;
        j_next = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && operation == OP_COMPUTE)
                begin
                    state_next = ST_READ;
                    i_next = '0;
                    k_next = '0;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:
            begin
                if (k_reg == side_m1)
                begin
                    state_next = ST_EMIT;
                    j_next = '0;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    j_next = j_reg + 1'b1;
                    if (j_reg == side_m1)
                    begin
                        if (i_reg == side_m1)
                            state_next = ST_IDLE;
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            k_next = '0;
                            state_next = ST_READ;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg <= '0;
            k_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            k_reg <= k_next;
            j_reg <= j_next;
        end
    end

    // Outputs of the sequencer.
    cell_ctl_t ctl;
    logic      mul_en;
    always_comb
    begin
        ctl = '0;
        mul_en = 1'b0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_READ: ctl.clear = (k_reg == '0);
            ST_MUL:  mul_en = 1'b1;
            ST_ACC:  ctl.load = 1'b1;
            ST_EMIT:
            begin
                out_valid = 1'b1;
                ctl.shift = out_ready;
            end
            default: ;
        endcase
    end

    // Cell chain: cell c holds C[i][c]; shifts toward cell 0 on each beat.
    logic [DataW-1:0] acc [MaxSide];
    for (genvar c = 0; c < MaxSide; c++)
    begin : g_cell
        logic [DataW-1:0] sin;
        if (c == MaxSide - 1)
        begin : g_end
            assign sin = '0;
        end
        else
        begin : g_mid
            assign sin = acc[c+1];
        end
        smm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .mul_en   (mul_en),
            .a_in     (a_rd_reg),
            .b_in     (b_rd_reg[c]),
            .shift_in (sin),
            .acc_out  (acc[c])
        );
    end

    assign out_row   = i_reg;
    assign out_col   = j_reg;
    assign out_value = acc[0];
    assign last      = (i_reg == side_m1) && (j_reg == side_m1);

    // Results only leave while the row is being emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_EMIT)
        else $error("result outside emit");
    // No new item is taken while a product is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("ready during compute");
    // Last beat returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last) |=> state_reg == ST_IDLE)
        else $error("no idle after last");
endmodule
`default_nettype wire
